// ===== design/kld_pkg.sv =====
// Shared types, constants and lookup functions for the keypad layer decoder.
package kld_pkg;

  // Key matrix geometry; the event code maps onto a row stride of ten keys.
  localparam int KEY_ROWS   = 4;
  localparam int KEY_COLS   = 10;
  localparam int ROW_STRIDE = 10;
  localparam int ROM_SIZE   = 40;
  localparam int KEY_W      = $clog2(ROM_SIZE);

  // Event byte layout.
  localparam int EVT_PRESS_BIT = 7;
  localparam int EVT_CODE_W    = 7;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CNT_W      = 16;
  localparam logic [CNT_W-1:0] START_DELAY_RST = 16'd350;
  localparam logic [CNT_W-1:0] INTERVAL_RST    = 16'd150;

  // Queue between the front and back parts.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Special characters and ROM markers.
  localparam logic [7:0] MK_FN    = 8'hF0;
  localparam logic [7:0] MK_SHIFT = 8'hF1;
  localparam logic [7:0] CH_ENTER = 8'd13;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_NONE  = 8'd0;

  // Navigation lanes.
  localparam int NAV_N    = 4;
  localparam int NAV_UP   = 0;
  localparam int NAV_DOWN = 1;
  localparam int NAV_PREV = 2;
  localparam int NAV_NEXT = 3;

  // Layer selection codes.
  typedef enum logic [1:0] {
    LAYER_BASE  = 2'd0,
    LAYER_SHIFT = 2'd1,
    LAYER_FN    = 2'd2
  } layer_t;

  // Classes of key events as seen by the front part.
  typedef enum logic [1:0] {
    KC_CHAR  = 2'd0,
    KC_FN    = 2'd1,
    KC_SHIFT = 2'd2
  } key_class_t;

  // One queued item.
  typedef struct packed {
    logic             is_tick;
    logic             pressed;
    key_class_t       cls;
    logic [KEY_W-1:0] key;
    logic             waking;
    logic             sel;
  } kld_item_t;

  // Queue status seen by the front part.
  typedef struct packed {
    logic full;
    logic empty;
  } kld_qstat_t;

  // One result transaction.
  typedef struct packed {
    logic             char_valid;
    logic [7:0]       char_code;
    logic             is_enter;
    logic             is_erase;
    logic             with_select;
    logic [NAV_N-1:0] nav;
  } kld_result_t;

  // Navigation lookup result.
  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } kld_nav_t;

  localparam logic [7:0] ROM_BASE [ROM_SIZE] = '{
    "q", "w", "e", "r", "t", "y", "u", "i", "o", "p",
    "a", "s", "d", "f", "g", "h", "j", "k", "l", CH_ENTER,
    MK_FN, "z", "x", "c", "v", "b", "n", "m", MK_SHIFT, CH_BS,
    " ", CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE
  };

  localparam logic [7:0] ROM_SHIFT [ROM_SIZE] = '{
    "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P",
    "A", "S", "D", "F", "G", "H", "J", "K", "L", CH_ENTER,
    MK_FN, "Z", "X", "C", "V", "B", "N", "M", MK_SHIFT, CH_BS,
    " ", CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE
  };

  localparam logic [7:0] ROM_FN [ROM_SIZE] = '{
    "1", "2", "3", "4", "5", "6", "7", "8", "9", "0",
    "*", "/", "+", "-", "=", ":", 8'h27, 8'h22, "@", CH_ENTER,
    MK_FN, "_", "$", ";", "?", "!", ",", ".", CH_NONE, CH_BS,
    " ", CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE
  };

  // Character of one key in one layer; keys beyond the ROM read as empty.
  function automatic logic [7:0] rom_char(layer_t layer, logic [KEY_W-1:0] k);
    logic [7:0] ch;
    ch = CH_NONE;
    if (int'(k) < ROM_SIZE) begin
      unique case (layer)
        LAYER_BASE:  ch = ROM_BASE[k];
        LAYER_SHIFT: ch = ROM_SHIFT[k];
        LAYER_FN:    ch = ROM_FN[k];
        default:     ch = CH_NONE;
      endcase
    end
    return ch;
  endfunction

  // Navigation lane of a character, if it has one.
  function automatic kld_nav_t nav_of(logic [7:0] ch);
    kld_nav_t n;
    n = '0;
    unique case (ch)
      "w":     begin n.hit = 1'b1; n.idx = 2'(NAV_UP);   end
      "s":     begin n.hit = 1'b1; n.idx = 2'(NAV_DOWN); end
      "a":     begin n.hit = 1'b1; n.idx = 2'(NAV_PREV); end
      "d":     begin n.hit = 1'b1; n.idx = 2'(NAV_NEXT); end
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

// ===== design/kld_front.sv =====
// Front part: accepts input transactions, drops invalid key codes and classifies the rest.
module kld_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic [7:0]        event_byte,
  input  logic              screen_waking,
  input  logic              select_held,
  input  kld_pkg::kld_qstat_t q_stat,
  output logic              push,
  output kld_pkg::kld_item_t push_item
);
  import kld_pkg::*;

  logic                  accept;
  logic [EVT_CODE_W-1:0] code;
  logic [EVT_CODE_W-1:0] k_full;
  logic                  key_ok;
  logic [7:0]            base_ch;

  // Is a key number inside the populated part of the matrix?
  function automatic logic in_matrix(logic [EVT_CODE_W-1:0] k);
    logic ok;
    ok = 1'b0;
    for (int r = 0; r < KEY_ROWS; r++) begin
      if (k >= EVT_CODE_W'(r * ROW_STRIDE) &&
          k <  EVT_CODE_W'(r * ROW_STRIDE + KEY_COLS))
        ok = 1'b1;
    end
    return ok;
  endfunction

  // Input is held off only while the queue has no free slot.
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  // Key decode: code zero and keys off the matrix are discarded here.
  assign code    = event_byte[EVT_CODE_W-1:0];
  assign k_full  = code - EVT_CODE_W'(1);
  assign key_ok  = (code != '0) && in_matrix(k_full) && (int'(k_full) < ROM_SIZE);
  assign base_ch = rom_char(LAYER_BASE, k_full[KEY_W-1:0]);

  // Build the queued item.
  always_comb begin
    push_item.is_tick = mode;
    push_item.pressed = event_byte[EVT_PRESS_BIT];
    push_item.key     = k_full[KEY_W-1:0];
    push_item.waking  = screen_waking;
    push_item.sel     = select_held;
    if (base_ch == MK_FN) begin
      push_item.cls = KC_FN;
    end else if (base_ch == MK_SHIFT) begin
      push_item.cls = KC_SHIFT;
    end else begin
      push_item.cls = KC_CHAR;
    end
  end

  // Ticks always go through; key events only when the code is valid.
  assign push = accept && (mode || key_ok);

endmodule

// ===== design/kld_queue.sv =====
// Short queue between the front and back parts of the keypad decoder.
module kld_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  kld_pkg::kld_item_t  push_item,
  input  logic                pop,
  output kld_pkg::kld_item_t  head,
  output kld_pkg::kld_qstat_t q_stat
);
  import kld_pkg::*;

  kld_item_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  // Pointer advance with wrap at the queue depth.
  function automatic logic [QPTR_W-1:0] bump(logic [QPTR_W-1:0] p);
    return (int'(p) == QDEPTH - 1) ? '0 : p + QPTR_W'(1);
  endfunction

  assign q_stat.full  = (int'(count) == QDEPTH);
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slots[rd_ptr];

  // Slot storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== design/kld_back.sv =====
// Back part: holds the key state and repeat timers and produces the result transactions.
module kld_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [kld_pkg::CNT_W-1:0] start_delay,
  input  logic [kld_pkg::CNT_W-1:0] interval,
  input  kld_pkg::kld_item_t        head,
  input  logic                      q_empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output kld_pkg::kld_result_t      out_res
);
  import kld_pkg::*;

  logic             fn_latch;
  logic             fn_latch_next;
  logic             shift_down;
  logic             shift_down_next;
  logic             caps_on;
  logic             caps_on_next;
  logic [NAV_N-1:0] nav_held;
  logic [NAV_N-1:0] nav_held_next;
  logic [CNT_W-1:0] countdown      [NAV_N];
  logic [CNT_W-1:0] countdown_next [NAV_N];
  logic [CNT_W-1:0] dec;
  layer_t           layer;
  logic [7:0]       ch;
  kld_nav_t         nav;
  logic             emit;
  kld_result_t      res;

  // Take the head item whenever the output register is free or being emptied.
  assign pop = !q_empty && (!out_valid || !out_stall);

  // Next state and result for the head item.
  always_comb begin
    fn_latch_next   = fn_latch;
    shift_down_next = shift_down;
    caps_on_next    = caps_on;
    nav_held_next   = nav_held;
    countdown_next  = countdown;
    res             = '0;
    emit            = 1'b0;
    dec             = '0;
    layer           = LAYER_BASE;
    ch              = CH_NONE;
    nav             = '0;

    if (head.is_tick) begin
      // Each lane counts down; a held key fires when it reaches zero.
      for (int i = 0; i < NAV_N; i++) begin
        dec = (countdown[i] != '0) ? countdown[i] - CNT_W'(1) : countdown[i];
        if (nav_held[i] && dec == '0) begin
          res.nav[i]        = 1'b1;
          countdown_next[i] = interval;
        end else begin
          countdown_next[i] = dec;
        end
      end
      emit = |res.nav;
    end else begin
      unique case (head.cls)
        KC_FN: begin
          fn_latch_next = !fn_latch;
        end
        KC_SHIFT: begin
          shift_down_next = head.pressed;
          if (fn_latch && head.pressed) begin
            caps_on_next = !caps_on;
          end
        end
        default: begin
          // Layer choice: function first, then shift against caps lock.
          if (fn_latch) begin
            layer = LAYER_FN;
          end else if (shift_down != caps_on) begin
            layer = LAYER_SHIFT;
          end else begin
            layer = LAYER_BASE;
          end
          ch  = rom_char(layer, head.key);
          nav = nav_of(ch);
          if (head.pressed && !head.waking && ch != CH_NONE) begin
            emit            = 1'b1;
            res.char_valid  = 1'b1;
            res.char_code   = ch;
            res.is_enter    = (ch == CH_ENTER);
            res.is_erase    = (ch == CH_BS);
            res.with_select = head.sel;
            if (nav.hit) begin
              res.nav[nav.idx]          = 1'b1;
              countdown_next[nav.idx]   = start_delay;
            end
          end
          if (nav.hit) begin
            nav_held_next[nav.idx] = head.pressed;
          end
        end
      endcase
    end
  end

  // Key state and repeat timers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fn_latch   <= 1'b0;
      shift_down <= 1'b0;
      caps_on    <= 1'b0;
      nav_held   <= '0;
      for (int i = 0; i < NAV_N; i++) begin
        countdown[i] <= '0;
      end
    end else if (pop) begin
      fn_latch   <= fn_latch_next;
      shift_down <= shift_down_next;
      caps_on    <= caps_on_next;
      nav_held   <= nav_held_next;
      countdown  <= countdown_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_res <= res;
    end
  end

endmodule

// ===== design/keypad_layer_decoder_with_repeat.sv =====
// Top level of the keypad layer decoder with auto-repeat of the navigation keys.
//
// Input channel (in_valid/in_stall): one transaction is either a key matrix event
// byte (mode 0) or a one millisecond tick (mode 1). Output channel
// (out_valid/out_stall): one transaction is a typed character with its flags, or a
// set of navigation pulses. An input gives at most one output.
// An accepted input is written into the queue; the back part pops it when the
// output register is free or being emptied and loads its result there.
// Throughput: one input per cycle while in_stall is low; the front part classifies
// and writes a two-entry queue, and the back part updates the key state and repeat
// timers for each item and loads the output register.
// When the receiver stalls, the held result stays on the outputs, the back part
// stops taking items and in_stall rises once the queue is full.
// Reset (rst, synchronous) clears the latches, held flags and timers, empties the
// queue and output, and sets the start delay to 350 ms and the interval to 150 ms.
// Registers on the APB port: start delay at byte address 0, interval at 4.
module keypad_layer_decoder_with_repeat (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [kld_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [kld_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [kld_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           mode,
  input  logic [7:0]                     event_byte,
  input  logic                           screen_waking,
  input  logic                           select_held,
  // Output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           char_valid,
  output logic [7:0]                     char_code,
  output logic                           is_enter,
  output logic                           is_erase,
  output logic                           with_select,
  output logic                           nav_up,
  output logic                           nav_down,
  output logic                           nav_prev,
  output logic                           nav_next
);
  import kld_pkg::*;

  localparam logic REG_START_DELAY = 1'b0;
  localparam logic REG_INTERVAL    = 1'b1;

  logic [CNT_W-1:0] start_delay;
  logic [CNT_W-1:0] interval;
  logic             cfg_write;
  logic             reg_sel;
  logic             push;
  logic             pop;
  kld_item_t        push_item;
  kld_item_t        head;
  kld_qstat_t       q_stat;
  kld_result_t      out_res;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_delay <= START_DELAY_RST;
      interval    <= INTERVAL_RST;
    end else if (cfg_write) begin
      if (reg_sel == REG_START_DELAY) begin
        start_delay <= pwdata[CNT_W-1:0];
      end else begin
        interval <= pwdata[CNT_W-1:0];
      end
    end
  end

  assign prdata = (reg_sel == REG_INTERVAL) ? CFG_DATA_W'(interval) : CFG_DATA_W'(start_delay);

  // Front part.
  kld_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .event_byte    (event_byte),
    .screen_waking (screen_waking),
    .select_held   (select_held),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item)
  );

  // Queue between the parts.
  kld_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Back part.
  kld_back u_back (
    .clk         (clk),
    .rst         (rst),
    .start_delay (start_delay),
    .interval    (interval),
    .head        (head),
    .q_empty     (q_stat.empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (out_res)
  );

  // Result fields.
  assign char_valid  = out_res.char_valid;
  assign char_code   = out_res.char_code;
  assign is_enter    = out_res.is_enter;
  assign is_erase    = out_res.is_erase;
  assign with_select = out_res.with_select;
  assign nav_up      = out_res.nav[NAV_UP];
  assign nav_down    = out_res.nav[NAV_DOWN];
  assign nav_prev    = out_res.nav[NAV_PREV];
  assign nav_next    = out_res.nav[NAV_NEXT];

`ifndef ASSERT_OFF
  // A result is either a character or carries at least one navigation pulse.
  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_valid || nav_up || nav_down || nav_prev || nav_next))
    else $error("result transaction carries neither character nor pulse");

  // A character result carries at most one navigation pulse.
  a_char_one_nav: assert property (@(posedge clk) disable iff (rst)
    (out_valid && char_valid) |-> $onehot0({nav_up, nav_down, nav_prev, nav_next}))
    else $error("character result with several navigation pulses");

  // Enter and erase flags agree with the character code.
  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((is_enter == (char_valid && char_code == CH_ENTER)) &&
                   (is_erase == (char_valid && char_code == CH_BS))))
    else $error("enter or erase flag does not match character");

  // The back part only takes items from a queue that holds some.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue read while empty");
`endif

endmodule

// ===== tb/keypad_layer_decoder_with_repeat_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the keypad layer decoder: directed rows, random key sequences.
module keypad_layer_decoder_with_repeat_tb;
  import kld_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_ITEMS   = 150;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam int N_DIRECTED    = 25;

  // Register indexes on the configuration port.
  localparam int REG_START_DELAY = 0;
  localparam int REG_INTERVAL    = 1;

  // Key codes (key number plus one) of the keys the random sequences use.
  localparam logic [6:0] FN_KEY_CODE    = 7'd21;
  localparam logic [6:0] SHIFT_KEY_CODE = 7'd29;
  localparam logic [6:0] NAV_KEY_CODE [NAV_N] = '{7'd2, 7'd12, 7'd11, 7'd13};

  // Character layers, indexed by layer and key number.
  localparam logic [7:0] KEYMAP [3][ROM_SIZE] = '{
    '{"q", "w", "e", "r", "t", "y", "u", "i", "o", "p",
      "a", "s", "d", "f", "g", "h", "j", "k", "l", CH_ENTER,
      MK_FN, "z", "x", "c", "v", "b", "n", "m", MK_SHIFT, CH_BS,
      " ", CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE},
    '{"Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P",
      "A", "S", "D", "F", "G", "H", "J", "K", "L", CH_ENTER,
      MK_FN, "Z", "X", "C", "V", "B", "N", "M", MK_SHIFT, CH_BS,
      " ", CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE},
    '{"1", "2", "3", "4", "5", "6", "7", "8", "9", "0",
      "*", "/", "+", "-", "=", ":", 8'h27, 8'h22, "@", CH_ENTER,
      MK_FN, "_", "$", ";", "?", "!", ",", ".", CH_NONE, CH_BS,
      " ", CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE, CH_NONE}
  };

  typedef struct packed {
    logic             char_valid;
    logic [7:0]       char_code;
    logic             is_enter;
    logic             is_erase;
    logic             with_select;
    logic [NAV_N-1:0] nav;
  } keypad_result_t;

  typedef struct packed {
    logic           tick;
    logic [7:0]     evt;
    logic           waking;
    logic           sel;
    logic           typed;
    keypad_result_t res;
  } directed_row_t;

  // Directed rows; a typed result replaces the prediction for that row.
  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0, '0},                                     // tick, nothing held
    '{1'b0, 8'h81, 1'b0, 1'b1, 1'b1, '{1'b1, "q", 1'b0, 1'b0, 1'b1, 4'b0000}},
    '{1'b0, 8'h01, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 8'h94, 1'b0, 1'b0, 1'b1, '{1'b1, CH_ENTER, 1'b1, 1'b0, 1'b0, 4'b0000}},
    '{1'b0, 8'h9E, 1'b0, 1'b0, 1'b1, '{1'b1, CH_BS, 1'b0, 1'b1, 1'b0, 4'b0000}},
    '{1'b0, 8'h80, 1'b0, 1'b0, 1'b0, '0},                                     // code zero
    '{1'b0, 8'hA9, 1'b0, 1'b0, 1'b0, '0},                                     // past the ROM
    '{1'b0, 8'hFF, 1'b1, 1'b1, 1'b0, '0},
    '{1'b0, 8'h9F, 1'b0, 1'b0, 1'b1, '{1'b1, " ", 1'b0, 1'b0, 1'b0, 4'b0000}},
    '{1'b0, 8'hA8, 1'b0, 1'b0, 1'b0, '0},                                     // empty entry
    '{1'b0, 8'h82, 1'b1, 1'b0, 1'b0, '0},                                     // wake press of w
    '{1'b0, 8'h02, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 8'h82, 1'b0, 1'b0, 1'b1, '{1'b1, "w", 1'b0, 1'b0, 1'b0, 4'b0001}},
    '{1'b1, 8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 8'h02, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 8'h9D, 1'b0, 1'b0, 1'b0, '0},                                     // shift press
    '{1'b0, 8'h8B, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 8'h1D, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 8'h95, 1'b0, 1'b0, 1'b0, '0},                                     // fn latches
    '{1'b0, 8'h9D, 1'b0, 1'b0, 1'b0, '0},                                     // caps lock on
    '{1'b0, 8'h1D, 1'b0, 1'b0, 1'b0, '0},
    '{1'b0, 8'h8B, 1'b0, 1'b1, 1'b0, '0},                                     // third layer
    '{1'b0, 8'h15, 1'b0, 1'b0, 1'b0, '0},                                     // fn unlatches
    '{1'b0, 8'h8D, 1'b0, 1'b0, 1'b0, '0},                                     // d under caps
    '{1'b0, 8'h7F, 1'b1, 1'b1, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  mode = 1'b0;
  logic [7:0]            event_byte = '0;
  logic                  screen_waking = 1'b0;
  logic                  select_held = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  char_valid;
  logic [7:0]            char_code;
  logic                  is_enter;
  logic                  is_erase;
  logic                  with_select;
  logic                  nav_up;
  logic                  nav_down;
  logic                  nav_prev;
  logic                  nav_next;

  // Decoder state as the testbench predicts it.
  logic [15:0] start_delay_reg;
  logic [15:0] interval_reg;
  logic        fn_on;
  logic        shift_on;
  logic        caps_latched;
  logic        held [NAV_N];
  logic [15:0] countdown [NAV_N];

  keypad_result_t awaited_results [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int nav_results_seen = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  keypad_layer_decoder_with_repeat u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .event_byte(event_byte),
    .screen_waking(screen_waking), .select_held(select_held),
    .out_valid(out_valid), .out_stall(out_stall),
    .char_valid(char_valid), .char_code(char_code), .is_enter(is_enter),
    .is_erase(is_erase), .with_select(with_select),
    .nav_up(nav_up), .nav_down(nav_down), .nav_prev(nav_prev), .nav_next(nav_next)
  );

  always #CLK_HALF clk = ~clk;

  // Navigation lane of a character, or -1 when it has none.
  function automatic int nav_lane(logic [7:0] ch);
    case (ch)
      "w":     return NAV_UP;
      "s":     return NAV_DOWN;
      "a":     return NAV_PREV;
      "d":     return NAV_NEXT;
      default: return -1;
    endcase
  endfunction

  // Advances the predicted state by one item and returns whether it gives a result.
  function automatic bit decode_item(input logic tick, input logic [7:0] evt,
                                     input logic waking, input logic sel,
                                     output keypad_result_t r);
    bit         any;
    bit         pressed;
    int         k;
    int         lane;
    layer_t     layer;
    logic [7:0] ch;
    r = '0;
    any = 1'b0;
    if (tick) begin
      for (int i = 0; i < NAV_N; i++) begin
        if (countdown[i] != 0) countdown[i] = countdown[i] - 16'd1;
        if (held[i] && countdown[i] == 0) begin
          r.nav[i] = 1'b1;
          countdown[i] = interval_reg;
          any = 1'b1;
        end
      end
      return any;
    end
    pressed = evt[EVT_PRESS_BIT];
    k = int'(evt[EVT_CODE_W-1:0]) - 1;
    if (k < 0 || k / ROW_STRIDE >= KEY_ROWS || k % ROW_STRIDE >= KEY_COLS || k >= ROM_SIZE)
      return 1'b0;
    // Function and shift keys only change the latches.
    if (KEYMAP[int'(LAYER_BASE)][k] == MK_FN) begin
      fn_on = !fn_on;
      return 1'b0;
    end
    if (KEYMAP[int'(LAYER_BASE)][k] == MK_SHIFT) begin
      shift_on = pressed;
      if (fn_on && pressed) caps_latched = !caps_latched;
      return 1'b0;
    end
    if (fn_on) layer = LAYER_FN;
    else if (shift_on != caps_latched) layer = LAYER_SHIFT;
    else layer = LAYER_BASE;
    ch = KEYMAP[int'(layer)][k];
    lane = nav_lane(ch);
    if (pressed && !waking && ch != CH_NONE) begin
      any = 1'b1;
      r.char_valid = 1'b1;
      r.char_code = ch;
      r.is_enter = (ch == CH_ENTER);
      r.is_erase = (ch == CH_BS);
      r.with_select = sel;
      if (lane >= 0) begin
        r.nav[lane] = 1'b1;
        countdown[lane] = start_delay_reg;
      end
    end
    if (lane >= 0) held[lane] = pressed;
    return any;
  endfunction

  // Drives one input transaction, waits for it to be taken and records the outcome.
  task automatic send_item(input logic tick, input logic [7:0] evt, input logic waking,
                           input logic sel, input logic typed, input keypad_result_t typed_res);
    keypad_result_t r;
    bit             has;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= tick;
    event_byte    <= evt;
    screen_waking <= waking;
    select_held   <= sel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = decode_item(tick, evt, waking, sel, r);
    if (typed) begin
      r = typed_res;
      has = 1'b1;
    end
    if (has) awaited_results.insert(awaited_results.size(), r);
    if (tick || (evt[EVT_CODE_W-1:0] != 0 && int'(evt[EVT_CODE_W-1:0]) <= ROM_SIZE))
      items_sent++;
  endtask

  // Stops sending and waits until every awaited result has arrived and the block is quiet.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one register, reads it back and updates the predicted configuration.
  task automatic write_register(input int idx, input logic [15:0] value);
    logic [CFG_DATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * idx);
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_START_DELAY: start_delay_reg = value;
      REG_INTERVAL:    interval_reg = value;
      default:         ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (readback[15:0] !== value) begin
      $error("register %0d: expected %0d, got %0d", idx, value, readback[15:0]);
      errors++;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result monitor and random receiver stall.
  always @(posedge clk) begin
    keypad_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        errors++;
      end else begin
        want = awaited_results.pop_front();
        results_seen++;
        if (want.nav != 0) nav_results_seen++;
        check_field("char_valid", 8'(want.char_valid), 8'(char_valid));
        check_field("char_code", want.char_code, char_code);
        check_field("is_enter", 8'(want.is_enter), 8'(is_enter));
        check_field("is_erase", 8'(want.is_erase), 8'(is_erase));
        check_field("with_select", 8'(want.with_select), 8'(with_select));
        check_field("nav_up", 8'(want.nav[NAV_UP]), 8'(nav_up));
        check_field("nav_down", 8'(want.nav[NAV_DOWN]), 8'(nav_down));
        check_field("nav_prev", 8'(want.nav[NAV_PREV]), 8'(nav_prev));
        check_field("nav_next", 8'(want.nav[NAV_NEXT]), 8'(nav_next));
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Main sequence: reset, directed rows, then four random phases.
  initial begin
    int phase_base;
    int pick;
    int lane;
    int lane2;
    bit second;
    bit reconfigured;
    start_delay_reg = START_DELAY_RST;
    interval_reg    = INTERVAL_RST;
    fn_on = 1'b0;
    shift_on = 1'b0;
    caps_latched = 1'b0;
    for (int i = 0; i < NAV_N; i++) begin
      held[i] = 1'b0;
      countdown[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset configuration.
    for (int i = 0; i < N_DIRECTED; i++)
      send_item(DIRECTED_ROWS[i].tick, DIRECTED_ROWS[i].evt, DIRECTED_ROWS[i].waking,
                DIRECTED_ROWS[i].sel, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

    for (int ph = 0; ph < 4; ph++) begin
      drain_block();
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      case (ph)
        0: begin write_register(REG_START_DELAY, 16'd3); write_register(REG_INTERVAL, 16'd2); end
        1: begin write_register(REG_START_DELAY, 16'd0); write_register(REG_INTERVAL, 16'd1); end
        default: begin
          write_register(REG_START_DELAY, 16'($urandom_range(1, 20)));
          write_register(REG_INTERVAL, 16'($urandom_range(1, 10)));
        end
      endcase
      phase_base = items_sent;
      reconfigured = 1'b0;
      while (items_sent - phase_base < PHASE_ITEMS) begin
        // Halfway through, the sender holds off until the block is empty and
        // the repeat timing is changed; the last phase goes to the upper limits.
        if (!reconfigured && items_sent - phase_base >= PHASE_ITEMS / 2) begin
          reconfigured = 1'b1;
          drain_block();
          if (ph == 3) begin
            write_register(REG_START_DELAY, 16'hFFFF);
            write_register(REG_INTERVAL, 16'hFFFF);
          end else begin
            write_register(REG_START_DELAY, 16'($urandom_range(0, 30)));
            write_register(REG_INTERVAL, 16'($urandom_range(1, 15)));
          end
        end
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          // Navigation hold: mostly bring the layers back to lower case, then press, tick, release.
          if ($urandom_range(0, 4) != 0) begin
            if (fn_on) send_item(1'b0, {1'b1, FN_KEY_CODE}, 1'b0, 1'b0, 1'b0, '0);
            if (shift_on != caps_latched)
              send_item(1'b0, {caps_latched, SHIFT_KEY_CODE}, 1'b0, 1'b0, 1'b0, '0);
          end
          lane = $urandom_range(0, NAV_N - 1);
          lane2 = $urandom_range(0, NAV_N - 1);
          second = ($urandom_range(0, 3) == 0);
          send_item(1'b0, {1'b1, NAV_KEY_CODE[lane]}, $urandom_range(0, 9) == 0,
                    1'($urandom_range(0, 1)), 1'b0, '0);
          if (second)
            send_item(1'b0, {1'b1, NAV_KEY_CODE[lane2]}, 1'b0, 1'($urandom_range(0, 1)),
                      1'b0, '0);
          repeat ($urandom_range(0, 25))
            send_item(1'b1, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'b0, '0);
          send_item(1'b0, {1'b0, NAV_KEY_CODE[lane]}, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b0, '0);
          if (second)
            send_item(1'b0, {1'b0, NAV_KEY_CODE[lane2]}, 1'b0, 1'b0, 1'b0, '0);
        end else if (pick < 65) begin
          // Ordinary key stroke on any key of the matrix.
          lane = $urandom_range(1, ROM_SIZE);
          send_item(1'b0, {1'b1, 7'(lane)}, $urandom_range(0, 9) == 0,
                    1'($urandom_range(0, 1)), 1'b0, '0);
          if ($urandom_range(0, 9) < 7)
            send_item(1'b0, {1'b0, 7'(lane)}, 1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
        end else if (pick < 75) begin
          send_item(1'b0, {1'($urandom_range(0, 1)), FN_KEY_CODE}, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b0, '0);
        end else if (pick < 85) begin
          send_item(1'b0, {1'($urandom_range(0, 1)), SHIFT_KEY_CODE}, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b0, '0);
        end else if (pick < 90) begin
          // Noise: any byte, either mode.
          send_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          repeat ($urandom_range(1, 5))
            send_item(1'b1, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'b0, '0);
        end
      end
    end

    drain_block();
    if (awaited_results.size() != 0) begin
      $error("%0d expected results never arrived", awaited_results.size());
      errors++;
    end
    $display("Checked %0d result transactions (%0d with navigation pulses) from %0d inputs.",
             results_seen, nav_results_seen, items_sent);
    $display("Repeat timing ran from no delay to the upper register limits in four stall mixes.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/kld_pkg.sv
design/kld_front.sv
design/kld_queue.sv
design/kld_back.sv
design/keypad_layer_decoder_with_repeat.sv
tb/keypad_layer_decoder_with_repeat_tb.sv
